// ===== sv/assert_macros.svh =====
// assertion macros used by the port-level checker file
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, masked while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication that also holds through reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/sfd_pkg.sv =====
// shared constants, codes and transaction types of the steering decider
// no dependencies
package sfd_pkg;

   // sample and averaging widths
   localparam int SAMPLE_BITS   = 12;
   localparam int SENSOR_BITS   = 12;
   localparam int PRIME_SAMPLES = 10;
   localparam int AVG_COUNT     = 5;
   localparam int SUM_BITS      = 15;
   localparam int RECIP         = 52429;
   localparam int RECIP_SHIFT   = 18;
   localparam int PROD_BITS     = SUM_BITS + 17;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MASK = SAMPLE_BITS'((1 << SENSOR_BITS) - 1);

   // result list sizing
   localparam int MAX_RES     = 5;
   localparam int CNT_BITS    = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;

   // modes and followed sides
   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_OBJECT = 2'd1;
   localparam logic [1:0] MODE_WALL   = 2'd2;
   localparam logic [1:0] MODE_RSVD   = 2'd3;
   localparam logic [1:0] SIDE_LEFT   = 2'd1;
   localparam logic [1:0] SIDE_RIGHT  = 2'd2;

   // motor commands
   localparam logic [3:0] CMD_STOP        = 4'd0;
   localparam logic [3:0] CMD_FWD         = 4'd1;
   localparam logic [3:0] CMD_BACK        = 4'd2;
   localparam logic [3:0] CMD_TURN_BACK_R = 4'd3;
   localparam logic [3:0] CMD_TURN_BACK_L = 4'd4;
   localparam logic [3:0] CMD_TURN_FWD_L  = 4'd5;
   localparam logic [3:0] CMD_TURN_FWD_R  = 4'd6;
   localparam logic [3:0] CMD_PIVOT_L     = 4'd7;
   localparam logic [3:0] CMD_PIVOT_R     = 4'd8;
   localparam logic [3:0] CMD_RW_STEER_L  = 4'd9;
   localparam logic [3:0] CMD_RW_STEER_R  = 4'd10;
   localparam logic [3:0] CMD_LW_STEER_L  = 4'd11;
   localparam logic [3:0] CMD_LW_STEER_R  = 4'd12;
   localparam logic [3:0] CMD_NONE        = 4'd13;

   // led colours
   localparam logic [2:0] LED_KEEP   = 3'd0;
   localparam logic [2:0] LED_RED    = 3'd1;
   localparam logic [2:0] LED_GREEN  = 3'd2;
   localparam logic [2:0] LED_BLUE   = 3'd3;
   localparam logic [2:0] LED_PURPLE = 3'd4;
   localparam logic [2:0] LED_CYAN   = 3'd5;
   localparam logic [2:0] LED_ORANGE = 3'd6;

   // hold times in 10 ms units
   localparam logic [5:0] HOLD_NONE   = 6'd0;
   localparam logic [5:0] HOLD_LOOP   = 6'd8;
   localparam logic [5:0] HOLD_CORNER = 6'd40;

   // motion and turn states
   localparam logic [1:0] MOTION_IDLE  = 2'd0;
   localparam logic [1:0] MOTION_FWD   = 2'd1;
   localparam logic [1:0] MOTION_CLOSE = 2'd2;
   localparam logic [1:0] TURN_NONE    = 2'd0;
   localparam logic [1:0] TURN_RIGHT   = 2'd1;
   localparam logic [1:0] TURN_LEFT    = 2'd2;

   // one result item
   typedef struct packed {
      logic [3:0] cmd;
      logic [2:0] led;
      logic [5:0] hold;
   } item_type;

   // one decision's result list, last item is cnt-1
   typedef struct packed {
      logic [CNT_BITS-1:0]     cnt;
      item_type [MAX_RES-1:0]  items;
   } desc_type;

endpackage

// ===== sv/sfd_front.sv =====
// front part: accepts sample transactions, primes, sums, averages and decides
// depends on sfd_pkg; queues one result list per decision or mode change
module sfd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_mode,
   input  logic [sfd_pkg::SAMPLE_BITS-1:0] req_left_sample,
   input  logic [sfd_pkg::SAMPLE_BITS-1:0] req_front_sample,
   input  logic [sfd_pkg::SAMPLE_BITS-1:0] req_right_sample,
   input  logic [1:0]                      followed_side,
   input  logic                            q_full,
   output logic                            push,
   output sfd_pkg::desc_type               push_desc
);

   typedef struct packed {
      logic       mc;
      logic       prime;
      logic       decide;
      logic       wall;
      logic [3:0] mc_cmd;
      logic [2:0] mc_led;
   } op_type;

   localparam int SB = sfd_pkg::SAMPLE_BITS;

   // append one item unless the list is full
   function automatic sfd_pkg::desc_type put(sfd_pkg::desc_type d, logic [3:0] c,
                                             logic [2:0] l, logic [5:0] h);
      sfd_pkg::desc_type r;
      r = d;
      if (r.cnt < sfd_pkg::CNT_BITS'(sfd_pkg::MAX_RES)) begin
         r.items[r.cnt] = '{cmd: c, led: l, hold: h};
         r.cnt = r.cnt + 1'b1;
      end
      return r;
   endfunction

   // close a list: empty gets a no-change item, last item takes the hold
   function automatic sfd_pkg::desc_type finish(sfd_pkg::desc_type d, logic [5:0] h);
      sfd_pkg::desc_type r;
      r = d;
      if (r.cnt == '0) begin
         r = put(r, sfd_pkg::CMD_NONE, sfd_pkg::LED_KEEP, sfd_pkg::HOLD_NONE);
      end
      r.items[r.cnt - 1'b1].hold = h;
      return r;
   endfunction

   function automatic logic [SB-1:0] absdiff(logic [SB-1:0] a, logic [SB-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   logic adv;
   logic accept;
   assign adv       = !q_full;
   assign req_ready = adv;
   assign accept    = req_valid && adv;

   // accept stage state
   logic [1:0]                   mode_ff, mode_in;
   logic [3:0]                   cnt_ff, cnt_in;
   logic                         primed_ff, primed_in;
   logic [sfd_pkg::SUM_BITS-1:0] sum_ff [3];
   logic [sfd_pkg::SUM_BITS-1:0] sum_in [3];
   op_type                       a_op;
   logic [sfd_pkg::SUM_BITS-1:0] a_val [3];
   logic [SB-1:0]                smp [3];
   logic [1:0]                   mode_eff;

   assign smp[0]   = req_left_sample  & sfd_pkg::SAMPLE_MASK;
   assign smp[1]   = req_front_sample & sfd_pkg::SAMPLE_MASK;
   assign smp[2]   = req_right_sample & sfd_pkg::SAMPLE_MASK;
   assign mode_eff = (req_mode == sfd_pkg::MODE_RSVD) ? sfd_pkg::MODE_OFF : req_mode;

   // classify the transaction: mode change, priming, summing or decision
   always_comb begin
      logic [3:0]                   nxt_cnt;
      logic [sfd_pkg::SUM_BITS-1:0] sum_n [3];
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      primed_in = primed_ff;
      sum_in    = sum_ff;
      a_op      = '0;
      nxt_cnt   = '0;
      for (int i = 0; i < 3; i++) begin
         a_val[i] = sfd_pkg::SUM_BITS'(smp[i]);
         sum_n[i] = sum_ff[i] + sfd_pkg::SUM_BITS'(smp[i]);
      end
      if (accept) begin
         if (mode_eff != mode_ff) begin
            a_op.mc     = 1'b1;
            a_op.mc_cmd = (mode_ff == sfd_pkg::MODE_WALL) ? sfd_pkg::CMD_STOP
                                                          : sfd_pkg::CMD_NONE;
            if (mode_eff == sfd_pkg::MODE_OBJECT) begin
               a_op.mc_led = sfd_pkg::LED_BLUE;
            end else if (mode_eff == sfd_pkg::MODE_WALL) begin
               a_op.mc_led = sfd_pkg::LED_GREEN;
            end else begin
               a_op.mc_led = (mode_ff == sfd_pkg::MODE_WALL) ? sfd_pkg::LED_GREEN
                                                             : sfd_pkg::LED_BLUE;
            end
            mode_in   = mode_eff;
            cnt_in    = '0;
            primed_in = 1'b0;
            for (int i = 0; i < 3; i++) begin
               sum_in[i] = '0;
               sum_n[i]  = sfd_pkg::SUM_BITS'(smp[i]);
            end
         end
         a_op.wall = (mode_eff == sfd_pkg::MODE_WALL);
         if (mode_eff != sfd_pkg::MODE_OFF) begin
            nxt_cnt = cnt_in + 4'd1;
            if (!primed_in) begin
               if (nxt_cnt >= 4'(sfd_pkg::PRIME_SAMPLES)) begin
                  a_op.prime = 1'b1;
                  primed_in  = 1'b1;
                  cnt_in     = '0;
                  for (int i = 0; i < 3; i++) sum_in[i] = '0;
               end else begin
                  cnt_in = nxt_cnt;
               end
            end else if (nxt_cnt >= 4'(sfd_pkg::AVG_COUNT)) begin
               a_op.decide = 1'b1;
               cnt_in      = '0;
               for (int i = 0; i < 3; i++) begin
                  a_val[i]  = sum_n[i];
                  sum_in[i] = '0;
               end
            end else begin
               cnt_in = nxt_cnt;
               sum_in = sum_n;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= sfd_pkg::MODE_OFF;
         cnt_ff    <= '0;
         primed_ff <= 1'b0;
         for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
      end else begin
         mode_ff   <= mode_in;
         cnt_ff    <= cnt_in;
         primed_ff <= primed_in;
         sum_ff    <= sum_in;
      end
   end

   // stage 1 register
   logic                         s1_valid_ff;
   op_type                       s1_op_ff;
   logic [sfd_pkg::SUM_BITS-1:0] s1_val_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept && (a_op.mc || a_op.prime || a_op.decide);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff  <= a_op;
         s1_val_ff <= a_val;
      end
   end

   // stage 2: divide decision sums by five through a reciprocal multiply, pass other values through
   logic                          s2_valid_ff;
   op_type                        s2_op_ff;
   logic [SB-1:0]                 s2_val_ff [3];
   logic [sfd_pkg::PROD_BITS-1:0] prod [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[i] = sfd_pkg::PROD_BITS'(s1_val_ff[i]) * sfd_pkg::PROD_BITS'(sfd_pkg::RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_op_ff <= s1_op_ff;
         for (int i = 0; i < 3; i++) begin
            s2_val_ff[i] <= s1_op_ff.decide ? prod[i][sfd_pkg::RECIP_SHIFT +: SB]
                                            : s1_val_ff[i][SB-1:0];
         end
      end
   end

   // stage 3: decision state and result list
   logic [SB-1:0] prev_ff [3];
   logic [SB-1:0] prev_in [3];
   logic [1:0]    motion_ff, motion_in;
   logic [1:0]    turn_ff, turn_in;
   logic [7:0]    hcnt_ff, hcnt_in;
   sfd_pkg::desc_type d;

   always_comb begin
      logic [SB-1:0]        l, f, r;
      logic [SB-1:0]        dl, dr;
      logic [SB:0]          r2, l3, r3;
      logic signed [SB+1:0] lr;
      logic [7:0]           hc;
      logic                 cond_r, cond_l, corner_r, corner_l;
      l = s2_val_ff[0];
      f = s2_val_ff[1];
      r = s2_val_ff[2];
      dl = absdiff(l, prev_ff[0]);
      dr = absdiff(r, prev_ff[2]);
      r2 = (r > SB'(100)) ? {1'b0, r} + (SB+1)'(180) : {1'b0, r};
      lr = $signed({2'b00, l}) - $signed({1'b0, r2});
      hc = hcnt_ff + 8'd1;
      cond_r = (lr > (SB+2)'(300) && l > SB'(2100)) || ({1'b0, l} > r2 + (SB+1)'(400));
      cond_l = (lr < -(SB+2)'(200) && r2 > (SB+1)'(1610)) || (r2 + (SB+1)'(300) < {1'b0, l});
      l3 = (l > SB'(100)) ? {1'b0, l} + (SB+1)'(100) : {1'b0, l};
      r3 = (r > SB'(100)) ? {1'b0, r} + (SB+1)'(100) : {1'b0, r};
      corner_r = followed_side == sfd_pkg::SIDE_RIGHT && f > SB'(2585) && r > SB'(1490);
      corner_l = followed_side == sfd_pkg::SIDE_LEFT && f > SB'(2585) && l > SB'(1700);

      d         = '0;
      prev_in   = prev_ff;
      motion_in = motion_ff;
      turn_in   = turn_ff;
      hcnt_in   = hcnt_ff;

      if (s2_valid_ff) begin
         // mode change restarts motion tracking
         if (s2_op_ff.mc) begin
            d = put(d, s2_op_ff.mc_cmd, s2_op_ff.mc_led, sfd_pkg::HOLD_NONE);
            d = finish(d, sfd_pkg::HOLD_NONE);
            motion_in = sfd_pkg::MOTION_IDLE;
         end
         // end of priming loads the previous-average register with the last priming sample
         if (s2_op_ff.prime) begin
            prev_in = s2_val_ff;
         end
         if (s2_op_ff.decide) begin
            prev_in = s2_val_ff;
            if (!s2_op_ff.wall) begin
               // object follower
               if (dl > SB'(400) || dr > SB'(550)) begin
                  d = put(d, sfd_pkg::CMD_STOP, sfd_pkg::LED_RED, sfd_pkg::HOLD_NONE);
               end else if (f > SB'(2585) || l > SB'(2660) || r > SB'(2485)) begin
                  if (motion_ff != sfd_pkg::MOTION_CLOSE) begin
                     d = put(d, sfd_pkg::CMD_STOP, sfd_pkg::LED_PURPLE, sfd_pkg::HOLD_NONE);
                     motion_in = sfd_pkg::MOTION_CLOSE;
                  end
               end else begin
                  if (f < SB'(1600) && f > SB'(675)) begin
                     if (motion_ff != sfd_pkg::MOTION_FWD) begin
                        d = put(d, sfd_pkg::CMD_FWD, sfd_pkg::LED_GREEN, sfd_pkg::HOLD_NONE);
                        motion_in = sfd_pkg::MOTION_FWD;
                     end
                  end
                  if (cond_r) begin
                     hcnt_in = hc;
                     if (hc > 8'd2 || turn_ff != sfd_pkg::TURN_RIGHT) begin
                        d = put(d, sfd_pkg::CMD_TURN_BACK_R, sfd_pkg::LED_CYAN,
                                sfd_pkg::HOLD_NONE);
                        turn_in = sfd_pkg::TURN_RIGHT;
                        hcnt_in = '0;
                     end
                  end else if (cond_l) begin
                     hcnt_in = hc;
                     if (hc > 8'd2 || turn_ff != sfd_pkg::TURN_LEFT) begin
                        d = put(d, sfd_pkg::CMD_TURN_BACK_L, sfd_pkg::LED_ORANGE,
                                sfd_pkg::HOLD_NONE);
                        turn_in = sfd_pkg::TURN_LEFT;
                        hcnt_in = '0;
                     end
                  end else begin
                     turn_in = sfd_pkg::TURN_NONE;
                     hcnt_in = '0;
                  end
                  // forward trims
                  if ((l < SB'(1800) && l > SB'(680)) ||
                      (r2 < (SB+1)'(1840) && r2 > (SB+1)'(490))) begin
                     if (l < SB'(1880) && l > SB'(760)) begin
                        d = put(d, sfd_pkg::CMD_TURN_FWD_L, sfd_pkg::LED_BLUE,
                                sfd_pkg::HOLD_NONE);
                        motion_in = sfd_pkg::MOTION_IDLE;
                     end
                     if (r2 < (SB+1)'(1890) && r2 > (SB+1)'(490)) begin
                        d = put(d, sfd_pkg::CMD_TURN_FWD_R, sfd_pkg::LED_BLUE,
                                sfd_pkg::HOLD_NONE);
                        motion_in = sfd_pkg::MOTION_IDLE;
                     end
                  end
               end
               d = finish(d, sfd_pkg::HOLD_LOOP);
            end else if (corner_r || corner_l) begin
               // corner: stop, back up, stop, pivot, stop
               d = put(d, sfd_pkg::CMD_STOP, sfd_pkg::LED_RED, sfd_pkg::HOLD_NONE);
               d = put(d, sfd_pkg::CMD_BACK, sfd_pkg::LED_KEEP, sfd_pkg::HOLD_CORNER);
               d = put(d, sfd_pkg::CMD_STOP, sfd_pkg::LED_KEEP, sfd_pkg::HOLD_NONE);
               d = put(d, corner_r ? sfd_pkg::CMD_PIVOT_L : sfd_pkg::CMD_PIVOT_R,
                       sfd_pkg::LED_KEEP, sfd_pkg::HOLD_CORNER);
               d = put(d, sfd_pkg::CMD_STOP, sfd_pkg::LED_GREEN, sfd_pkg::HOLD_NONE);
               d = finish(d, sfd_pkg::HOLD_NONE);
            end else begin
               // wall steering by followed side
               if (followed_side == sfd_pkg::SIDE_RIGHT) begin
                  if (r3 > (SB+1)'(2010)) begin
                     d = put(d, sfd_pkg::CMD_RW_STEER_L, sfd_pkg::LED_ORANGE,
                             sfd_pkg::HOLD_NONE);
                  end else begin
                     d = put(d, sfd_pkg::CMD_RW_STEER_R, sfd_pkg::LED_CYAN,
                             sfd_pkg::HOLD_NONE);
                  end
               end else if (followed_side == sfd_pkg::SIDE_LEFT) begin
                  if (l3 > (SB+1)'(2300)) begin
                     d = put(d, sfd_pkg::CMD_LW_STEER_R, sfd_pkg::LED_ORANGE,
                             sfd_pkg::HOLD_NONE);
                  end else begin
                     d = put(d, sfd_pkg::CMD_LW_STEER_L, sfd_pkg::LED_CYAN,
                             sfd_pkg::HOLD_NONE);
                  end
               end
               d = finish(d, sfd_pkg::HOLD_LOOP);
            end
         end
      end
   end

   assign push      = adv && s2_valid_ff && (s2_op_ff.mc || s2_op_ff.decide);
   assign push_desc = d;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) prev_ff[i] <= '0;
         motion_ff <= sfd_pkg::MOTION_IDLE;
         turn_ff   <= sfd_pkg::TURN_NONE;
         hcnt_ff   <= '0;
      end else if (adv) begin
         prev_ff   <= prev_in;
         motion_ff <= motion_in;
         turn_ff   <= turn_in;
         hcnt_ff   <= hcnt_in;
      end
   end

endmodule

// ===== sv/sfd_queue.sv =====
// short queue of result lists between the front and the back
// depends on sfd_pkg
module sfd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sfd_pkg::desc_type push_desc,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output sfd_pkg::desc_type head
);

   sfd_pkg::desc_type               entry_ff [sfd_pkg::QUEUE_DEPTH];
   logic [sfd_pkg::QPTR_BITS-1:0]   wr_ptr_ff;
   logic [sfd_pkg::QPTR_BITS-1:0]   rd_ptr_ff;
   logic [sfd_pkg::QPTR_BITS:0]     count_ff;

   assign full  = (count_ff == (sfd_pkg::QPTR_BITS+1)'(sfd_pkg::QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head  = entry_ff[rd_ptr_ff];

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_desc;
   end

endmodule

// ===== sv/sfd_back.sv =====
// back part: walks a result list, one result transaction per unstalled cycle
// depends on sfd_pkg; output register decouples the receiver
module sfd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  sfd_pkg::desc_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [3:0]        rsp_motor_command,
   output logic [2:0]        rsp_led_colour,
   output logic [5:0]        rsp_hold_time,
   output logic              rsp_last_of_decision
);

   logic                            busy_ff;
   sfd_pkg::desc_type               desc_ff;
   logic [sfd_pkg::CNT_BITS-1:0]    idx_ff;
   logic                            valid_ff;
   sfd_pkg::item_type               item_ff;
   logic                            last_ff;
   logic                            out_load;
   logic                            at_last;
   logic                            take;

   assign out_load = busy_ff && (!valid_ff || rsp_ready);
   assign at_last  = (idx_ff == desc_ff.cnt - 1'b1);
   assign take     = !busy_ff || (out_load && at_last);
   assign q_pop    = q_valid && take;

   // list walker
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (q_pop) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (out_load) begin
         if (at_last) begin
            busy_ff <= 1'b0;
         end
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) desc_ff <= q_head;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         item_ff <= desc_ff.items[idx_ff];
         last_ff <= at_last;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_motor_command    = item_ff.cmd;
   assign rsp_led_colour       = item_ff.led;
   assign rsp_hold_time        = item_ff.hold;
   assign rsp_last_of_decision = last_ff;

endmodule

// ===== sv/ir_follower_steering_decider.sv =====
// top level of the three-sensor steering decider
// depends on sfd_pkg, sfd_front, sfd_queue and sfd_back
//
// usage:
//   req_* carries one transaction per sensor triple: mode plus left, front and
//   right ADC counts. rsp_* returns motor command items with led colour and
//   hold time; rsp_last_of_decision marks the final item of one decision.
//   csr_write_enable/csr_write_data set the followed wall side (reset: right).
// timing:
//   while the queue is not full, the front takes one transaction per cycle
//   through a three-stage pipeline (classify/sum, divide-by-five multiply,
//   decision). each result list then waits in a two-entry queue between
//   front and back, is loaded into the back's list register and leaves item
//   by item through the output register, one item per cycle while rsp_ready
//   is high. a decision holds 1 to 5 items.
// reset:
//   synchronous, active high; clears mode, priming, sums, motion and turn
//   state, the queue and the output register.
// stall:
//   when the receiver holds rsp_ready low the output item holds; once the
//   queue fills, req_ready drops until the back drains a list.
module ir_follower_steering_decider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_mode,
   input  logic [sfd_pkg::SAMPLE_BITS-1:0] req_left_sample,
   input  logic [sfd_pkg::SAMPLE_BITS-1:0] req_front_sample,
   input  logic [sfd_pkg::SAMPLE_BITS-1:0] req_right_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [3:0]                      rsp_motor_command,
   output logic [2:0]                      rsp_led_colour,
   output logic [5:0]                      rsp_hold_time,
   output logic                            rsp_last_of_decision,
   input  logic                            csr_write_enable,
   input  logic [1:0]                      csr_write_data
);

   logic [1:0]        side_ff;
   logic              q_full;
   logic              q_push;
   logic              q_pop;
   logic              q_valid;
   sfd_pkg::desc_type q_in;
   sfd_pkg::desc_type q_head;

   // followed side register
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= sfd_pkg::SIDE_RIGHT;
      end else if (csr_write_enable) begin
         side_ff <= csr_write_data;
      end
   end

   sfd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_left_sample  (req_left_sample),
      .req_front_sample (req_front_sample),
      .req_right_sample (req_right_sample),
      .followed_side    (side_ff),
      .q_full           (q_full),
      .push             (q_push),
      .push_desc        (q_in)
   );

   sfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   sfd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_head               (q_head),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_motor_command    (rsp_motor_command),
      .rsp_led_colour       (rsp_led_colour),
      .rsp_hold_time        (rsp_hold_time),
      .rsp_last_of_decision (rsp_last_of_decision)
   );

endmodule

// ===== sv/sfd_checker.sv =====
// port-level checker for the steering decider, bound to the top level
// depends on sfd_pkg and assert_macros.svh
`include "assert_macros.svh"

module sfd_port_assertions (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_motor_command,
   input logic [2:0] rsp_led_colour,
   input logic [5:0] rsp_hold_time,
   input logic       rsp_last_of_decision
);

   // reset empties the output
   `ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)

   // a stalled result transaction holds
   `ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_motor_command) && $stable(rsp_led_colour) &&
      $stable(rsp_hold_time) && $stable(rsp_last_of_decision))

   // corner hold items sit mid-sequence, never at its end
   `ASSERT_IMPLIES(a_corner_not_last, clock, reset,
      rsp_valid && rsp_hold_time == sfd_pkg::HOLD_CORNER, !rsp_last_of_decision)

   // a decision ends with the loop hold or none
   `ASSERT_IMPLIES(a_last_hold, clock, reset, rsp_valid && rsp_last_of_decision,
      rsp_hold_time == sfd_pkg::HOLD_LOOP || rsp_hold_time == sfd_pkg::HOLD_NONE)

endmodule

bind ir_follower_steering_decider sfd_port_assertions u_sfd_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_motor_command    (rsp_motor_command),
   .rsp_led_colour       (rsp_led_colour),
   .rsp_hold_time        (rsp_hold_time),
   .rsp_last_of_decision (rsp_last_of_decision)
);

// ===== tb/sfd_checker.sv =====
`timescale 1ns / 100ps
// checker for the steering decider: watches the request, response and csr ports,
// predicts the command items of each decision and compares them in order
// depends on sfd_pkg
module sfd_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [1:0]                      req_mode,
   input  logic [sfd_pkg::SAMPLE_BITS-1:0] req_left_sample,
   input  logic [sfd_pkg::SAMPLE_BITS-1:0] req_front_sample,
   input  logic [sfd_pkg::SAMPLE_BITS-1:0] req_right_sample,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [3:0]                      rsp_motor_command,
   input  logic [2:0]                      rsp_led_colour,
   input  logic [5:0]                      rsp_hold_time,
   input  logic                            rsp_last_of_decision,
   input  logic                            csr_write_enable,
   input  logic [1:0]                      csr_write_data,
   output int                              outstanding_count,
   output int                              error_count,
   output int                              checked_count
);

   typedef struct packed {
      logic [3:0] cmd;
      logic [2:0] led;
      logic [5:0] hold;
      logic       last;
   } command_item_type;

   // expected command items, oldest first
   command_item_type expected_commands[$];
   // items of the decision being built
   command_item_type decision_items[sfd_pkg::MAX_RES];
   int               decision_len = 0;

   // predicted state of the block
   logic [1:0]                      follow_side;
   logic [1:0]                      active_mode;
   logic [3:0]                      triple_count;
   logic                            primed;
   logic [sfd_pkg::SUM_BITS-1:0]    sensor_sum[3];
   logic [sfd_pkg::SAMPLE_BITS-1:0] prev_avg[3];
   logic [1:0]                      motion;
   logic [1:0]                      turn_dir;
   logic [7:0]                      turn_hold;

   function automatic int abs_gap(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // append one item, a decision holds at most MAX_RES
   task automatic emit(input logic [3:0] cmd, input logic [2:0] led, input logic [5:0] hold);
      if (decision_len < sfd_pkg::MAX_RES) begin
         decision_items[decision_len] = {cmd, led, hold, 1'b0};
         decision_len++;
      end
   endtask

   // mark the final item and queue the whole decision
   task automatic close_decision(input logic [5:0] hold);
      if (decision_len == 0) begin
         emit(sfd_pkg::CMD_NONE, sfd_pkg::LED_KEEP, sfd_pkg::HOLD_NONE);
      end
      decision_items[decision_len-1].hold = hold;
      decision_items[decision_len-1].last = 1'b1;
      for (int i = 0; i < decision_len; i++) begin
         expected_commands.push_back(decision_items[i]);
      end
      decision_len = 0;
   endtask

   task automatic decide_object(input int l, input int f, input int r);
      int dl, dr, lr;
      dl = abs_gap(l, int'(prev_avg[0]));
      dr = abs_gap(r, int'(prev_avg[2]));
      prev_avg[0] = sfd_pkg::SAMPLE_BITS'(l);
      prev_avg[1] = sfd_pkg::SAMPLE_BITS'(f);
      prev_avg[2] = sfd_pkg::SAMPLE_BITS'(r);
      if (dl > 400 || dr > 550) begin
         // spike rejection
         emit(sfd_pkg::CMD_STOP, sfd_pkg::LED_RED, sfd_pkg::HOLD_NONE);
      end else if (f > 2585 || l > 2660 || r > 2485) begin
         // too close, stop once
         if (motion != sfd_pkg::MOTION_CLOSE) begin
            emit(sfd_pkg::CMD_STOP, sfd_pkg::LED_PURPLE, sfd_pkg::HOLD_NONE);
            motion = sfd_pkg::MOTION_CLOSE;
         end
      end else begin
         if (f < 1600 && f > 675 && motion != sfd_pkg::MOTION_FWD) begin
            emit(sfd_pkg::CMD_FWD, sfd_pkg::LED_GREEN, sfd_pkg::HOLD_NONE);
            motion = sfd_pkg::MOTION_FWD;
         end
         // right sensor bias
         if (r > 100) r = r + 180;
         lr = l - r;
         if ((lr > 300 && l > 2100) || l > r + 400) begin
            turn_hold = turn_hold + 8'd1;
            if (turn_hold > 2 || turn_dir != sfd_pkg::TURN_RIGHT) begin
               emit(sfd_pkg::CMD_TURN_BACK_R, sfd_pkg::LED_CYAN, sfd_pkg::HOLD_NONE);
               turn_dir  = sfd_pkg::TURN_RIGHT;
               turn_hold = '0;
            end
         end else if ((lr < -200 && r > 1610) || r + 300 < l) begin
            turn_hold = turn_hold + 8'd1;
            if (turn_hold > 2 || turn_dir != sfd_pkg::TURN_LEFT) begin
               emit(sfd_pkg::CMD_TURN_BACK_L, sfd_pkg::LED_ORANGE, sfd_pkg::HOLD_NONE);
               turn_dir  = sfd_pkg::TURN_LEFT;
               turn_hold = '0;
            end
         end else begin
            turn_dir  = sfd_pkg::TURN_NONE;
            turn_hold = '0;
         end
         // forward trims
         if ((l < 1800 && l > 680) || (r < 1840 && r > 490)) begin
            if (l < 1880 && l > 760) begin
               emit(sfd_pkg::CMD_TURN_FWD_L, sfd_pkg::LED_BLUE, sfd_pkg::HOLD_NONE);
               motion = sfd_pkg::MOTION_IDLE;
            end
            if (r < 1890 && r > 490) begin
               emit(sfd_pkg::CMD_TURN_FWD_R, sfd_pkg::LED_BLUE, sfd_pkg::HOLD_NONE);
               motion = sfd_pkg::MOTION_IDLE;
            end
         end
      end
      close_decision(sfd_pkg::HOLD_LOOP);
   endtask

   task automatic decide_wall(input int l, input int f, input int r);
      logic corner_r, corner_l;
      corner_r = follow_side == sfd_pkg::SIDE_RIGHT && f > 2585 && r > 1490;
      corner_l = follow_side == sfd_pkg::SIDE_LEFT && f > 2585 && l > 1700;
      prev_avg[0] = sfd_pkg::SAMPLE_BITS'(l);
      prev_avg[1] = sfd_pkg::SAMPLE_BITS'(f);
      prev_avg[2] = sfd_pkg::SAMPLE_BITS'(r);
      if (corner_r || corner_l) begin
         // backup and pivot away from the corner
         emit(sfd_pkg::CMD_STOP, sfd_pkg::LED_RED, sfd_pkg::HOLD_NONE);
         emit(sfd_pkg::CMD_BACK, sfd_pkg::LED_KEEP, sfd_pkg::HOLD_CORNER);
         emit(sfd_pkg::CMD_STOP, sfd_pkg::LED_KEEP, sfd_pkg::HOLD_NONE);
         emit(corner_r ? sfd_pkg::CMD_PIVOT_L : sfd_pkg::CMD_PIVOT_R, sfd_pkg::LED_KEEP,
              sfd_pkg::HOLD_CORNER);
         emit(sfd_pkg::CMD_STOP, sfd_pkg::LED_GREEN, sfd_pkg::HOLD_NONE);
         close_decision(sfd_pkg::HOLD_NONE);
      end else begin
         if (follow_side == sfd_pkg::SIDE_RIGHT) begin
            if (r > 100) r = r + 100;
            if (r > 2010) emit(sfd_pkg::CMD_RW_STEER_L, sfd_pkg::LED_ORANGE, sfd_pkg::HOLD_NONE);
            else emit(sfd_pkg::CMD_RW_STEER_R, sfd_pkg::LED_CYAN, sfd_pkg::HOLD_NONE);
         end else if (follow_side == sfd_pkg::SIDE_LEFT) begin
            if (l > 100) l = l + 100;
            if (l > 2300) emit(sfd_pkg::CMD_LW_STEER_R, sfd_pkg::LED_ORANGE, sfd_pkg::HOLD_NONE);
            else emit(sfd_pkg::CMD_LW_STEER_L, sfd_pkg::LED_CYAN, sfd_pkg::HOLD_NONE);
         end
         close_decision(sfd_pkg::HOLD_LOOP);
      end
   endtask

   // one accepted sensor transaction
   task automatic predict_triple(input logic [1:0] mode_in,
                                 input logic [sfd_pkg::SAMPLE_BITS-1:0] ls,
                                 input logic [sfd_pkg::SAMPLE_BITS-1:0] fs,
                                 input logic [sfd_pkg::SAMPLE_BITS-1:0] rs);
      logic [1:0]                      m;
      logic [2:0]                      led;
      logic [sfd_pkg::SAMPLE_BITS-1:0] s[3];
      int                              avg_l, avg_f, avg_r;
      m    = (mode_in == sfd_pkg::MODE_RSVD) ? sfd_pkg::MODE_OFF : mode_in;
      s[0] = ls & sfd_pkg::SAMPLE_MASK;
      s[1] = fs & sfd_pkg::SAMPLE_MASK;
      s[2] = rs & sfd_pkg::SAMPLE_MASK;
      // mode change announces itself and restarts priming
      if (m != active_mode) begin
         if (m == sfd_pkg::MODE_OBJECT) led = sfd_pkg::LED_BLUE;
         else if (m == sfd_pkg::MODE_WALL) led = sfd_pkg::LED_GREEN;
         else led = (active_mode == sfd_pkg::MODE_WALL) ? sfd_pkg::LED_GREEN
                                                         : sfd_pkg::LED_BLUE;
         emit(active_mode == sfd_pkg::MODE_WALL ? sfd_pkg::CMD_STOP : sfd_pkg::CMD_NONE,
              led, sfd_pkg::HOLD_NONE);
         close_decision(sfd_pkg::HOLD_NONE);
         active_mode  = m;
         triple_count = '0;
         primed       = 1'b0;
         motion       = sfd_pkg::MOTION_IDLE;
         foreach (sensor_sum[i]) sensor_sum[i] = '0;
      end
      if (active_mode != sfd_pkg::MODE_OFF) begin
         if (!primed) begin
            triple_count = triple_count + 4'd1;
            if (triple_count >= sfd_pkg::PRIME_SAMPLES) begin
               prev_avg     = s;
               primed       = 1'b1;
               triple_count = '0;
               foreach (sensor_sum[i]) sensor_sum[i] = '0;
            end
         end else begin
            foreach (sensor_sum[i]) sensor_sum[i] = sensor_sum[i] + s[i];
            triple_count = triple_count + 4'd1;
            if (triple_count >= sfd_pkg::AVG_COUNT) begin
               avg_l        = sensor_sum[0] / sfd_pkg::AVG_COUNT;
               avg_f        = sensor_sum[1] / sfd_pkg::AVG_COUNT;
               avg_r        = sensor_sum[2] / sfd_pkg::AVG_COUNT;
               triple_count = '0;
               foreach (sensor_sum[i]) sensor_sum[i] = '0;
               if (active_mode == sfd_pkg::MODE_OBJECT) decide_object(avg_l, avg_f, avg_r);
               else decide_wall(avg_l, avg_f, avg_r);
            end
         end
      end
   endtask

   task automatic check_field(input string name, input logic [5:0] want, input logic [5:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // one accepted command transaction
   task automatic check_command();
      command_item_type want;
      if (expected_commands.size() == 0) begin
         $error("unexpected command item: motor_command %0d", rsp_motor_command);
         error_count++;
      end else begin
         want = expected_commands.pop_front();
         checked_count++;
         check_field("motor_command", 6'(want.cmd), 6'(rsp_motor_command));
         check_field("led_colour", 6'(want.led), 6'(rsp_led_colour));
         check_field("hold_time", want.hold, rsp_hold_time);
         check_field("last_of_decision", 6'(want.last), 6'(rsp_last_of_decision));
      end
   endtask

   // sample all ports on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         follow_side   = sfd_pkg::SIDE_RIGHT;
         active_mode   = sfd_pkg::MODE_OFF;
         triple_count  = '0;
         primed        = 1'b0;
         motion        = sfd_pkg::MOTION_IDLE;
         turn_dir      = sfd_pkg::TURN_NONE;
         turn_hold     = '0;
         error_count   = 0;
         checked_count = 0;
         foreach (sensor_sum[i]) sensor_sum[i] = '0;
         foreach (prev_avg[i]) prev_avg[i] = '0;
         expected_commands.delete();
      end else begin
         if (csr_write_enable) follow_side = csr_write_data;
         if (req_valid && req_ready) begin
            predict_triple(req_mode, req_left_sample, req_front_sample, req_right_sample);
         end
         if (rsp_valid && rsp_ready) check_command();
      end
      outstanding_count <= expected_commands.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// top of the steering decider testbench: clock, reset, stimulus and verdict
// depends on sfd_pkg, ir_follower_steering_decider and sfd_checker
module tb_top;

   localparam int TRIPLE_TARGET = 330;
   localparam int SEGMENTS      = 6;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 250000;
   localparam int SAMPLE_MAX    = (1 << sfd_pkg::SAMPLE_BITS) - 1;

   // followed side values without steering
   localparam logic [1:0] SIDE_NONE  = 2'd0;
   localparam logic [1:0] SIDE_SPARE = 2'd3;

   logic                            clock;
   logic                            reset            = 1'b1;
   logic                            req_valid        = 1'b0;
   logic                            req_ready;
   logic [1:0]                      req_mode         = sfd_pkg::MODE_OFF;
   logic [sfd_pkg::SAMPLE_BITS-1:0] req_left_sample  = '0;
   logic [sfd_pkg::SAMPLE_BITS-1:0] req_front_sample = '0;
   logic [sfd_pkg::SAMPLE_BITS-1:0] req_right_sample = '0;
   logic                            rsp_valid;
   logic                            rsp_ready        = 1'b1;
   logic [3:0]                      rsp_motor_command;
   logic [2:0]                      rsp_led_colour;
   logic [5:0]                      rsp_hold_time;
   logic                            rsp_last_of_decision;
   logic                            csr_write_enable = 1'b0;
   logic [1:0]                      csr_write_data   = SIDE_NONE;

   int outstanding_count;
   int error_count;
   int checked_count;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int active_triples = 0;
   int cycle_count    = 0;

   ir_follower_steering_decider i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_left_sample      (req_left_sample),
      .req_front_sample     (req_front_sample),
      .req_right_sample     (req_right_sample),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_motor_command    (rsp_motor_command),
      .rsp_led_colour       (rsp_led_colour),
      .rsp_hold_time        (rsp_hold_time),
      .rsp_last_of_decision (rsp_last_of_decision),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   sfd_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_left_sample      (req_left_sample),
      .req_front_sample     (req_front_sample),
      .req_right_sample     (req_right_sample),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_motor_command    (rsp_motor_command),
      .rsp_led_colour       (rsp_led_colour),
      .rsp_hold_time        (rsp_hold_time),
      .rsp_last_of_decision (rsp_last_of_decision),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .outstanding_count    (outstanding_count),
      .error_count          (error_count),
      .checked_count        (checked_count)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int clamp_sample(input int v);
      if (v < 0) return 0;
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      return v;
   endfunction

   function automatic int jitter(input int v);
      return clamp_sample(v + int'($urandom_range(80)) - 40);
   endfunction

   function automatic int rand_sample();
      return int'($urandom_range(SAMPLE_MAX));
   endfunction

   // present one sensor transaction and wait until it is taken
   task automatic send_triple(input logic [1:0] mode, input int l, input int f, input int r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_left_sample  <= sfd_pkg::SAMPLE_BITS'(l);
      req_front_sample <= sfd_pkg::SAMPLE_BITS'(f);
      req_right_sample <= sfd_pkg::SAMPLE_BITS'(r);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (mode == sfd_pkg::MODE_OBJECT || mode == sfd_pkg::MODE_WALL) active_triples++;
   endtask

   // drop valid, wait for every expected item, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_side(input logic [1:0] side);
      csr_write_enable <= 1'b1;
      csr_write_data   <= side;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // priming then groups of five around a slowly wandering position,
   // with occasional jumps and now and then an early break
   task automatic run_episode(input logic [1:0] mode, input int budget);
      int groups, stop_at, sent;
      int walk_l, walk_f, walk_r;
      walk_l  = rand_sample();
      walk_f  = rand_sample();
      walk_r  = rand_sample();
      groups  = int'($urandom_range(2, 8));
      stop_at = ($urandom_range(9) == 0) ? int'($urandom_range(1, 14)) : 1000;
      if (stop_at > budget) stop_at = budget;
      sent    = 0;
      for (int i = 0; i < sfd_pkg::PRIME_SAMPLES && sent < stop_at; i++) begin
         send_triple(mode, jitter(walk_l), jitter(walk_f), jitter(walk_r));
         sent++;
      end
      for (int g = 0; g < groups && sent < stop_at; g++) begin
         if ($urandom_range(9) == 0) begin
            walk_l = rand_sample();
            walk_f = rand_sample();
            walk_r = rand_sample();
         end else begin
            walk_l = clamp_sample(walk_l + int'($urandom_range(600)) - 300);
            walk_f = clamp_sample(walk_f + int'($urandom_range(600)) - 300);
            walk_r = clamp_sample(walk_r + int'($urandom_range(600)) - 300);
         end
         for (int k = 0; k < sfd_pkg::AVG_COUNT && sent < stop_at; k++) begin
            send_triple(mode, jitter(walk_l), jitter(walk_f), jitter(walk_r));
            sent++;
         end
      end
   endtask

   // episodes in random modes, sprinkled with inactive transactions
   task automatic run_segment(input int quota);
      int goal;
      goal = active_triples + quota;
      while (active_triples < goal) begin
         if ($urandom_range(3) == 0) begin
            send_triple($urandom_range(1) ? sfd_pkg::MODE_RSVD : sfd_pkg::MODE_OFF,
                        rand_sample(), rand_sample(), rand_sample());
         end
         run_episode($urandom_range(1) ? sfd_pkg::MODE_WALL : sfd_pkg::MODE_OBJECT,
                     goal - active_triples);
      end
      settle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_side(sfd_pkg::SIDE_RIGHT);

      // directed: reserved and inactive modes are ignored while inactive
      send_triple(sfd_pkg::MODE_RSVD, 0, 0, 0);
      send_triple(sfd_pkg::MODE_OFF, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
      // full-scale wall run ends in the right-side corner sequence
      repeat (sfd_pkg::PRIME_SAMPLES + sfd_pkg::AVG_COUNT) begin
         send_triple(sfd_pkg::MODE_WALL, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
      end
      // mode changes wall to object to off to wall, then to reserved, which counts as off
      send_triple(sfd_pkg::MODE_OBJECT, 0, 0, 0);
      send_triple(sfd_pkg::MODE_OFF, 0, 0, 0);
      send_triple(sfd_pkg::MODE_WALL, 0, 0, 0);
      send_triple(sfd_pkg::MODE_RSVD, SAMPLE_MAX, 0, SAMPLE_MAX);
      settle();

      // random, sender idles less than receiver
      send_idle_pct = 34;
      recv_idle_pct = 71;
      write_side(sfd_pkg::SIDE_RIGHT);
      run_segment(TRIPLE_TARGET / SEGMENTS);
      write_side(SIDE_NONE);
      run_segment(TRIPLE_TARGET / SEGMENTS);

      // receiver idles less than sender
      send_idle_pct = 71;
      recv_idle_pct = 34;
      write_side(sfd_pkg::SIDE_LEFT);
      run_segment(TRIPLE_TARGET / SEGMENTS);
      write_side(SIDE_SPARE);
      run_segment(TRIPLE_TARGET / SEGMENTS);

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_side(sfd_pkg::SIDE_LEFT);
      run_segment(TRIPLE_TARGET / SEGMENTS);
      write_side(sfd_pkg::SIDE_RIGHT);
      run_segment(TRIPLE_TARGET / SEGMENTS);

      $display("summary: %0d sensor triples in object and wall modes, %0d command items checked",
               active_triples, checked_count);
      $display("summary: followed sides 0 to 3 under three idle patterns");
      if (error_count == 0 && outstanding_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
